// ----- design/spc_pkg.sv -----
// Shared constants for the segment pair closest point pipeline.
// No dependencies.
package spc_pkg;

    localparam int U_BITS      = 32;               // projection parameter, Q0.32
    localparam int DIV_STEP    = 2;                // quotient bits per divider stage
    localparam int DIV_STAGES  = U_BITS / DIV_STEP;
    localparam int PROJ_LAT    = 6 + DIV_STAGES;   // pipeline depth of spc_proj
    localparam int RANK_LAT    = 5;                // pipeline depth of spc_rank
    localparam int NUM_PTS     = 4;                // endpoints ranked per request
    localparam int LIMIT_WIDTH = 32;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 32'd42950;

endpackage

// ----- design/segment_pair_closest_points.sv -----
// Closest points between two 2D segments, signed fixed point.
// Fully pipelined; one request per clock.
// Each projection unit uses a 32-bit restoring divider.
// busy never rises and the result strobe is never held off.
// Reset (synchronous, active low) empties the pipeline and loads degenerate_limit = 42950.
// Depends on spc_pkg, spc_delay, spc_proj, spc_rank.
module segment_pair_closest_points
    import spc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_WIDTH-1:0] i_first_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_y,
    input  logic                         i_cfg_we,
    input  logic [LIMIT_WIDTH-1:0]       i_cfg_data,
    output logic                         o_valid,
    output logic signed [COORD_WIDTH-1:0] o_near_first_x,
    output logic signed [COORD_WIDTH-1:0] o_near_first_y,
    output logic signed [COORD_WIDTH-1:0] o_near_second_x,
    output logic signed [COORD_WIDTH-1:0] o_near_second_y
);

    localparam int W  = COORD_WIDTH;
    localparam int BW = 8 * W;

    // configuration
    logic [LIMIT_WIDTH-1:0] r_limit;

    // request coordinates: 0..3 first segment, 4..7 second segment
    logic signed [W-1:0] c_in  [8];
    logic [BW-1:0]       in_bus, cd_bus, ce_bus;
    logic signed [W-1:0] cd    [8];
    logic signed [W-1:0] ce    [8];

    // first pass: each endpoint onto the other segment
    logic                lane_v [NUM_PTS];
    logic signed [W-1:0] lp_x   [NUM_PTS];
    logic signed [W-1:0] lp_y   [NUM_PTS];
    logic signed [W-1:0] le_x   [NUM_PTS];
    logic signed [W-1:0] le_y   [NUM_PTS];
    logic [BW-1:0]       lp_bus, pe_bus;
    logic signed [W-1:0] pe_x   [NUM_PTS];
    logic signed [W-1:0] pe_y   [NUM_PTS];

    logic                rank_v;
    logic [1:0]          rank_win;

    // winner select
    logic                r_sel_v;
    logic                r_sel_first;
    logic signed [W-1:0] r_sel_px, r_sel_py;
    logic signed [W-1:0] r_sel_ax, r_sel_ay, r_sel_bx, r_sel_by;

    // second pass and output
    logic                back_v;
    logic signed [W-1:0] back_x, back_y;
    logic [2*W:0]        sel_bus, sel_dly;
    logic                dly_first;
    logic signed [W-1:0] dly_px, dly_py;
    logic                r_out_v;
    logic signed [W-1:0] r_fx, r_fy, r_sx, r_sy;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign c_in[0] = i_first_start_x;
    assign c_in[1] = i_first_start_y;
    assign c_in[2] = i_first_end_x;
    assign c_in[3] = i_first_end_y;
    assign c_in[4] = i_second_start_x;
    assign c_in[5] = i_second_start_y;
    assign c_in[6] = i_second_end_x;
    assign c_in[7] = i_second_end_y;

    for (genvar k = 0; k < 8; k++) begin : g_pack
        assign in_bus[k*W +: W] = c_in[k];
        assign cd[k]            = cd_bus[k*W +: W];
        assign ce[k]            = ce_bus[k*W +: W];
    end

    // endpoints held until their projections come out, then through ranking
    spc_delay #(.WIDTH(BW), .DEPTH(PROJ_LAT)) u_cdly (
        .i_clk  (i_clk),
        .i_data (in_bus),
        .o_data (cd_bus)
    );

    spc_delay #(.WIDTH(BW), .DEPTH(RANK_LAT)) u_edly (
        .i_clk  (i_clk),
        .i_data (cd_bus),
        .o_data (ce_bus)
    );

    // lanes 0,1: first segment's endpoints onto second; lanes 2,3: the reverse
    for (genvar k = 0; k < NUM_PTS; k++) begin : g_lane
        localparam int OS = (k < 2) ? 4 : 0;
        spc_proj #(.W(W)) u_proj (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (start),
            .i_px    (c_in[2*k]),
            .i_py    (c_in[2*k+1]),
            .i_ax    (c_in[OS]),
            .i_ay    (c_in[OS+1]),
            .i_bx    (c_in[OS+2]),
            .i_by    (c_in[OS+3]),
            .i_limit (r_limit),
            .o_valid (lane_v[k]),
            .o_x     (lp_x[k]),
            .o_y     (lp_y[k])
        );
        assign le_x[k] = cd[2*k];
        assign le_y[k] = cd[2*k+1];
        assign lp_bus[2*k*W +: W]     = lp_x[k];
        assign lp_bus[(2*k+1)*W +: W] = lp_y[k];
        assign pe_x[k] = pe_bus[2*k*W +: W];
        assign pe_y[k] = pe_bus[(2*k+1)*W +: W];
    end

    spc_rank #(.W(W)) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lane_v[0]),
        .i_ex    (le_x),
        .i_ey    (le_y),
        .i_px    (lp_x),
        .i_py    (lp_y),
        .o_valid (rank_v),
        .o_win   (rank_win)
    );

    spc_delay #(.WIDTH(BW), .DEPTH(RANK_LAT)) u_pdly (
        .i_clk  (i_clk),
        .i_data (lp_bus),
        .o_data (pe_bus)
    );

    // winner's first-pass projection is reused; it goes back onto the winner's own segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_v <= 1'b0;
        end else begin
            r_sel_v <= rank_v;
        end
        r_sel_first <= !rank_win[1];
        r_sel_px    <= pe_x[rank_win];
        r_sel_py    <= pe_y[rank_win];
        if (!rank_win[1]) begin
            r_sel_ax <= ce[0];
            r_sel_ay <= ce[1];
            r_sel_bx <= ce[2];
            r_sel_by <= ce[3];
        end else begin
            r_sel_ax <= ce[4];
            r_sel_ay <= ce[5];
            r_sel_bx <= ce[6];
            r_sel_by <= ce[7];
        end
    end

    spc_proj #(.W(W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sel_v),
        .i_px    (r_sel_px),
        .i_py    (r_sel_py),
        .i_ax    (r_sel_ax),
        .i_ay    (r_sel_ay),
        .i_bx    (r_sel_bx),
        .i_by    (r_sel_by),
        .i_limit (r_limit),
        .o_valid (back_v),
        .o_x     (back_x),
        .o_y     (back_y)
    );

    assign sel_bus = {r_sel_first, r_sel_px, r_sel_py};

    spc_delay #(.WIDTH(2*W+1), .DEPTH(PROJ_LAT)) u_sdly (
        .i_clk  (i_clk),
        .i_data (sel_bus),
        .o_data (sel_dly)
    );

    assign {dly_first, dly_px, dly_py} = sel_dly;

    // winner on first segment: back-projection lands on first, reused point on second
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= back_v;
        end
        r_fx <= dly_first ? back_x : dly_px;
        r_fy <= dly_first ? back_y : dly_py;
        r_sx <= dly_first ? dly_px : back_x;
        r_sy <= dly_first ? dly_py : back_y;
    end

    assign o_valid         = r_out_v;
    assign o_near_first_x  = r_fx;
    assign o_near_first_y  = r_fy;
    assign o_near_second_x = r_sx;
    assign o_near_second_y = r_sy;

endmodule

// ----- design/spc_delay.sv -----
// Fixed-depth shift line for payload that rides alongside the pipeline.
// Depends on nothing.
module spc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ----- design/spc_proj.sv -----
// Pipelined projection of a point onto a segment: products, restoring divide, rescale.
// Depends on spc_pkg.
module spc_proj
    import spc_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [W-1:0]    i_px,
    input  logic signed [W-1:0]    i_py,
    input  logic signed [W-1:0]    i_ax,
    input  logic signed [W-1:0]    i_ay,
    input  logic signed [W-1:0]    i_bx,
    input  logic signed [W-1:0]    i_by,
    input  logic [LIMIT_WIDTH-1:0] i_limit,
    output logic                   o_valid,
    output logic signed [W-1:0]    o_x,
    output logic signed [W-1:0]    o_y
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int RW = SW + 1;
    localparam int MW = DW + U_BITS;
    localparam int CW = 4 * W + 2 * DW + 5;

    // stage 1: differences
    logic                   r1_v;
    logic signed [W-1:0]    r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [DW-1:0]   r1_dx, r1_dy, r1_ex, r1_ey;
    logic [LIMIT_WIDTH-1:0] r1_lim;
    // stage 2: products
    logic                   r2_v;
    logic signed [W-1:0]    r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [DW-1:0]   r2_dx, r2_dy;
    logic signed [PW-1:0]   r2_xx, r2_yy, r2_nx, r2_ny;
    logic [LIMIT_WIDTH-1:0] r2_lim;
    // stage 3: sums
    logic                   r3_v;
    logic signed [W-1:0]    r3_ax, r3_ay, r3_bx, r3_by;
    logic signed [DW-1:0]   r3_dx, r3_dy;
    logic signed [SW-1:0]   r3_den, r3_num;
    logic [LIMIT_WIDTH-1:0] r3_lim;
    // stage 4 and divider
    logic                   n4_degen, n4_lo, n4_hi;
    logic [DW-1:0]          n4_mx, n4_my;
    logic                   r_dv  [DIV_STAGES+1];
    logic [RW-1:0]          r_rem [DIV_STAGES+1];
    logic [RW-1:0]          r_den [DIV_STAGES+1];
    logic [U_BITS-1:0]      r_q   [DIV_STAGES+1];
    logic [CW-1:0]          r_cv  [DIV_STAGES+1];
    logic [RW-1:0]          n_rem [DIV_STAGES];
    logic [U_BITS-1:0]      n_q   [DIV_STAGES];
    // after divider
    logic signed [W-1:0]    d_ax, d_ay, d_bx, d_by;
    logic [DW-1:0]          d_mx, d_my;
    logic                   d_sx, d_sy, d_degen, d_lo, d_hi;
    logic                   r5_v;
    logic signed [W-1:0]    r5_ax, r5_ay, r5_bx, r5_by;
    logic                   r5_sx, r5_sy, r5_degen, r5_lo, r5_hi;
    logic [MW-1:0]          r5_mx, r5_my;
    // output stage
    logic [MW-1:0]          n_rx, n_ry;
    logic signed [W+1:0]    n_ix, n_iy;
    logic signed [DW-1:0]   n_sumx, n_sumy;
    logic signed [W-1:0]    n_x, n_y;
    logic                   r_v;
    logic signed [W-1:0]    r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        r1_ax  <= i_ax;
        r1_ay  <= i_ay;
        r1_bx  <= i_bx;
        r1_by  <= i_by;
        r1_lim <= i_limit;
        r1_dx  <= $signed({i_bx[W-1], i_bx}) - $signed({i_ax[W-1], i_ax});
        r1_dy  <= $signed({i_by[W-1], i_by}) - $signed({i_ay[W-1], i_ay});
        r1_ex  <= $signed({i_px[W-1], i_px}) - $signed({i_ax[W-1], i_ax});
        r1_ey  <= $signed({i_py[W-1], i_py}) - $signed({i_ay[W-1], i_ay});

        r2_ax  <= r1_ax;
        r2_ay  <= r1_ay;
        r2_bx  <= r1_bx;
        r2_by  <= r1_by;
        r2_lim <= r1_lim;
        r2_dx  <= r1_dx;
        r2_dy  <= r1_dy;
        r2_xx  <= r1_dx * r1_dx;
        r2_yy  <= r1_dy * r1_dy;
        r2_nx  <= r1_ex * r1_dx;
        r2_ny  <= r1_ey * r1_dy;

        r3_ax  <= r2_ax;
        r3_ay  <= r2_ay;
        r3_bx  <= r2_bx;
        r3_by  <= r2_by;
        r3_lim <= r2_lim;
        r3_dx  <= r2_dx;
        r3_dy  <= r2_dy;
        r3_den <= $signed({r2_xx[PW-1], r2_xx}) + $signed({r2_yy[PW-1], r2_yy});
        r3_num <= $signed({r2_nx[PW-1], r2_nx}) + $signed({r2_ny[PW-1], r2_ny});
    end

    // special cases and magnitudes
    always_comb begin
        n4_degen = $unsigned(r3_den) < {{(SW-LIMIT_WIDTH){1'b0}}, r3_lim};
        n4_lo    = r3_num[SW-1] || (r3_num == '0);
        n4_hi    = r3_num >= r3_den;
        n4_mx    = r3_dx[DW-1] ? $unsigned(-r3_dx) : $unsigned(r3_dx);
        n4_my    = r3_dy[DW-1] ? $unsigned(-r3_dy) : $unsigned(r3_dy);
    end

    // restoring divide, DIV_STEP quotient bits per stage
    always_comb begin
        for (int g = 0; g < DIV_STAGES; g++) begin
            n_rem[g] = r_rem[g];
            n_q[g]   = r_q[g];
            for (int s = 0; s < DIV_STEP; s++) begin
                n_rem[g] = {n_rem[g][RW-2:0], 1'b0};
                n_q[g]   = {n_q[g][U_BITS-2:0], 1'b0};
                if (n_rem[g] >= r_den[g]) begin
                    n_rem[g] = n_rem[g] - r_den[g];
                    n_q[g][0] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g <= DIV_STAGES; g++) begin
                r_dv[g] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r3_v;
            for (int g = 0; g < DIV_STAGES; g++) begin
                r_dv[g+1] <= r_dv[g];
            end
        end
        r_rem[0] <= {1'b0, r3_num};
        r_den[0] <= {1'b0, r3_den};
        r_q[0]   <= '0;
        r_cv[0]  <= {r3_ax, r3_ay, r3_bx, r3_by, n4_mx, n4_my,
                     r3_dx[DW-1], r3_dy[DW-1], n4_degen, n4_lo, n4_hi};
        for (int g = 0; g < DIV_STAGES; g++) begin
            r_rem[g+1] <= n_rem[g];
            r_den[g+1] <= r_den[g];
            r_q[g+1]   <= n_q[g];
            r_cv[g+1]  <= r_cv[g];
        end
    end

    assign {d_ax, d_ay, d_bx, d_by, d_mx, d_my, d_sx, d_sy, d_degen, d_lo, d_hi} =
        r_cv[DIV_STAGES];

    // stage M: |d| * u
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r_dv[DIV_STAGES];
        end
        r5_ax    <= d_ax;
        r5_ay    <= d_ay;
        r5_bx    <= d_bx;
        r5_by    <= d_by;
        r5_sx    <= d_sx;
        r5_sy    <= d_sy;
        r5_degen <= d_degen;
        r5_lo    <= d_lo;
        r5_hi    <= d_hi;
        r5_mx    <= MW'(d_mx) * MW'(r_q[DIV_STAGES]);
        r5_my    <= MW'(d_my) * MW'(r_q[DIV_STAGES]);
    end

    // round half away from zero, add to start, pick the case
    always_comb begin
        n_rx   = r5_mx + (MW'(1) << (U_BITS - 1));
        n_ry   = r5_my + (MW'(1) << (U_BITS - 1));
        n_ix   = r5_sx ? $signed({{2{r5_ax[W-1]}}, r5_ax}) - $signed({1'b0, n_rx[MW-1:U_BITS]})
                       : $signed({{2{r5_ax[W-1]}}, r5_ax}) + $signed({1'b0, n_rx[MW-1:U_BITS]});
        n_iy   = r5_sy ? $signed({{2{r5_ay[W-1]}}, r5_ay}) - $signed({1'b0, n_ry[MW-1:U_BITS]})
                       : $signed({{2{r5_ay[W-1]}}, r5_ay}) + $signed({1'b0, n_ry[MW-1:U_BITS]});
        n_sumx = $signed({r5_ax[W-1], r5_ax}) + $signed({r5_bx[W-1], r5_bx});
        n_sumy = $signed({r5_ay[W-1], r5_ay}) + $signed({r5_by[W-1], r5_by});
        priority if (r5_degen) begin
            n_x = n_sumx[DW-1:1];
            n_y = n_sumy[DW-1:1];
        end else if (r5_lo) begin
            n_x = r5_ax;
            n_y = r5_ay;
        end else if (r5_hi) begin
            n_x = r5_bx;
            n_y = r5_by;
        end else begin
            n_x = n_ix[W-1:0];
            n_y = n_iy[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= r5_v;
        end
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// ----- design/spc_rank.sv -----
// Squared endpoint-to-projection distances and winner pick, earliest wins ties.
// Depends on spc_pkg.
module spc_rank
    import spc_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_ex [NUM_PTS],
    input  logic signed [W-1:0] i_ey [NUM_PTS],
    input  logic signed [W-1:0] i_px [NUM_PTS],
    input  logic signed [W-1:0] i_py [NUM_PTS],
    output logic                o_valid,
    output logic [1:0]          o_win
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [DW-1:0] r1_dx [NUM_PTS];
    logic signed [DW-1:0] r1_dy [NUM_PTS];
    logic signed [PW-1:0] r2_xx [NUM_PTS];
    logic signed [PW-1:0] r2_yy [NUM_PTS];
    logic signed [SW-1:0] r3_d  [NUM_PTS];
    logic signed [SW-1:0] r4_b01, r4_b23;
    logic                 r4_w01, r4_w23;
    logic [1:0]           r5_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        for (int k = 0; k < NUM_PTS; k++) begin
            r1_dx[k] <= $signed({i_ex[k][W-1], i_ex[k]}) - $signed({i_px[k][W-1], i_px[k]});
            r1_dy[k] <= $signed({i_ey[k][W-1], i_ey[k]}) - $signed({i_py[k][W-1], i_py[k]});
            r2_xx[k] <= r1_dx[k] * r1_dx[k];
            r2_yy[k] <= r1_dy[k] * r1_dy[k];
            r3_d[k]  <= $signed({r2_xx[k][PW-1], r2_xx[k]})
                      + $signed({r2_yy[k][PW-1], r2_yy[k]});
        end
        r4_w01 <= r3_d[1] < r3_d[0];
        r4_b01 <= (r3_d[1] < r3_d[0]) ? r3_d[1] : r3_d[0];
        r4_w23 <= r3_d[3] < r3_d[2];
        r4_b23 <= (r3_d[3] < r3_d[2]) ? r3_d[3] : r3_d[2];
        r5_win <= (r4_b23 < r4_b01) ? {1'b1, r4_w23} : {1'b0, r4_w01};
    end

    assign o_valid = r5_v;
    assign o_win   = r5_win;

endmodule
